@@ design/assert_macros.svh @@
// assertion helpers used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked while reset is asserted
`define LESF_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked while reset is asserted
`define LESF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/lesf_pkg.sv @@
`timescale 1ns / 1ps

package lesf_pkg;

    localparam int CHAR_W      = 8;
    localparam int GRID_W      = 11;
    localparam int OUT_SIZE_W  = 11;
    localparam int OUT_POS_W   = 10;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int LESF_MAX_SIDE = 1024;
    localparam int GRID_SIZE_MAX = (1 << GRID_W) - 1;

    localparam logic [CHAR_W-1:0] EMPTY_CHAR_RST = 8'd46;
    localparam logic [GRID_W-1:0] GRID_SIZE_RST  = 11'd1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EMPTY_CHAR = 2'd0,
        REG_GRID_SIZE  = 2'd1
    } t_cfg_reg;

    // per-cell position flags handed from the sequencer to the core
    typedef struct packed {
        logic top_row;
        logic left_col;
        logic grid_end;
    } t_cell_flags;

    // largest side the grid can actually reach
    function automatic int side_cap(input int max_side);
        return (max_side < GRID_SIZE_MAX) ? max_side : GRID_SIZE_MAX;
    endfunction

endpackage

@@ design/lesf_if.sv @@
`timescale 1ns / 1ps

interface lesf_cell_if import lesf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] cell_char;

    modport source (output valid, output cell_char, input ready);
    modport sink   (input valid, input cell_char, output ready);
endinterface

interface lesf_result_if import lesf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [OUT_SIZE_W-1:0] square_size;
    logic [OUT_POS_W-1:0]  square_col;
    logic [OUT_POS_W-1:0]  square_row;

    modport source (output valid, output square_size, output square_col,
                    output square_row, input ready);
    modport sink   (input valid, input square_size, input square_col,
                    input square_row, output ready);
endinterface

interface lesf_cfg_if import lesf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

@@ design/lesf_row_mem.sv @@
`timescale 1ns / 1ps

module lesf_row_mem #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 11
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]        o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/lesf_seq.sv @@
`timescale 1ns / 1ps

module lesf_seq import lesf_pkg::*; #(
    parameter int MAX_SIDE = LESF_MAX_SIDE
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    lesf_cfg_if.sink                               i_cfg,
    input  logic                                   i_accept,
    input  logic [CHAR_W-1:0]                      i_cell_char,
    output logic                                   o_free,
    output logic [$clog2(side_cap(MAX_SIDE))-1:0]  o_col,
    output logic [$clog2(side_cap(MAX_SIDE))-1:0]  o_row,
    output t_cell_flags                            o_flags
);

    localparam int SIDE_CAP = side_cap(MAX_SIDE);
    localparam int POS_W    = $clog2(SIDE_CAP);
    localparam logic [GRID_W-1:0] CAP_SIDE = GRID_W'(SIDE_CAP);

    logic [CHAR_W-1:0] r_empty_char;
    logic [GRID_W-1:0] r_grid_size;
    logic [POS_W-1:0]  r_col, n_col;
    logic [POS_W-1:0]  r_row, n_row;
    logic [GRID_W-1:0] side, last;
    logic              row_end, grid_end;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty_char <= EMPTY_CHAR_RST;
            r_grid_size  <= GRID_SIZE_RST;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.reg_index))
                REG_EMPTY_CHAR: r_empty_char <= i_cfg.wr_data[CHAR_W-1:0];
                REG_GRID_SIZE:  r_grid_size  <= i_cfg.wr_data[GRID_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        priority if (r_grid_size == '0) begin
            side = GRID_W'(1);
        end else if (r_grid_size > CAP_SIDE) begin
            side = CAP_SIDE;
        end else begin
            side = r_grid_size;
        end
        last     = side - GRID_W'(1);
        row_end  = GRID_W'(r_col) >= last;
        grid_end = row_end && (GRID_W'(r_row) >= last);

        priority if (grid_end) begin
            n_col = '0;
            n_row = '0;
        end else if (row_end) begin
            n_col = '0;
            n_row = r_row + POS_W'(1);
        end else begin
            n_col = r_col + POS_W'(1);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_free           = (i_cell_char == r_empty_char);
    assign o_col            = r_col;
    assign o_row            = r_row;
    assign o_flags.top_row  = (r_row == '0);
    assign o_flags.left_col = (r_col == '0);
    assign o_flags.grid_end = grid_end;

endmodule

@@ design/lesf_core.sv @@
`timescale 1ns / 1ps

module lesf_core import lesf_pkg::*; #(
    parameter int MAX_SIDE = LESF_MAX_SIDE
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_load,
    input  logic                                    i_free,
    input  logic [$clog2(side_cap(MAX_SIDE))-1:0]   i_col,
    input  logic [$clog2(side_cap(MAX_SIDE))-1:0]   i_row,
    input  t_cell_flags                             i_flags,
    input  logic [$clog2(side_cap(MAX_SIDE)+1)-1:0] i_up,
    output logic                                    o_ready,
    output logic                                    o_wr_en,
    output logic [$clog2(side_cap(MAX_SIDE))-1:0]   o_wr_addr,
    output logic [$clog2(side_cap(MAX_SIDE)+1)-1:0] o_wr_data,
    lesf_result_if.source                           o_result
);

    localparam int SIDE_CAP = side_cap(MAX_SIDE);
    localparam int POS_W    = $clog2(SIDE_CAP);
    localparam int SZ_W     = $clog2(SIDE_CAP + 1);

    logic              r_s1_valid;
    logic              r_s1_free;
    logic [POS_W-1:0]  r_s1_col, r_s1_row;
    t_cell_flags       r_s1_flags;

    logic [SZ_W-1:0]   r_left, r_diag;
    logic [SZ_W-1:0]   r_best_size, n_best_size;
    logic [POS_W-1:0]  r_best_col, n_best_col;
    logic [POS_W-1:0]  r_best_row, n_best_row;

    logic                  r_out_valid;
    logic [OUT_SIZE_W-1:0] r_out_size;
    logic [OUT_POS_W-1:0]  r_out_col, r_out_row;

    logic [SZ_W-1:0]   up, left, diag, min_ul, min_all, v;
    logic              advance;

    always_comb begin
        up      = r_s1_flags.top_row ? '0 : i_up;
        left    = r_s1_flags.left_col ? '0 : r_left;
        diag    = (r_s1_flags.top_row || r_s1_flags.left_col) ? '0 : r_diag;
        min_ul  = (up < left) ? up : left;
        min_all = (min_ul < diag) ? min_ul : diag;
        v       = r_s1_free ? min_all + SZ_W'(1) : '0;

        if (v > r_best_size) begin
            n_best_size = v;
            n_best_col  = r_s1_col - POS_W'(v - SZ_W'(1));
            n_best_row  = r_s1_row - POS_W'(v - SZ_W'(1));
        end else begin
            n_best_size = r_best_size;
            n_best_col  = r_best_col;
            n_best_row  = r_best_row;
        end
    end

    // a grid-ending cell waits only for room in the result register
    assign advance = r_s1_valid &&
                     (!r_s1_flags.grid_end || !r_out_valid || o_result.ready);
    assign o_ready = !r_s1_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_load) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s1_free  <= i_free;
            r_s1_col   <= i_col;
            r_s1_row   <= i_row;
            r_s1_flags <= i_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_diag      <= '0;
            r_best_size <= '0;
            r_best_col  <= '0;
            r_best_row  <= '0;
        end else if (advance) begin
            if (r_s1_flags.grid_end) begin
                r_left      <= '0;
                r_diag      <= '0;
                r_best_size <= '0;
                r_best_col  <= '0;
                r_best_row  <= '0;
            end else begin
                r_left      <= v;
                r_diag      <= up;
                r_best_size <= n_best_size;
                r_best_col  <= n_best_col;
                r_best_row  <= n_best_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_s1_flags.grid_end) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_flags.grid_end) begin
            r_out_size <= OUT_SIZE_W'(n_best_size);
            r_out_col  <= OUT_POS_W'(n_best_col);
            r_out_row  <= OUT_POS_W'(n_best_row);
        end
    end

    assign o_wr_en   = advance;
    assign o_wr_addr = r_s1_col;
    assign o_wr_data = v;

    assign o_result.valid       = r_out_valid;
    assign o_result.square_size = r_out_size;
    assign o_result.square_col  = r_out_col;
    assign o_result.square_row  = r_out_row;

endmodule

@@ design/largest_empty_square_finder_top.sv @@
`timescale 1ns / 1ps
// channel    direction  interface        payload
// i_cell     in         lesf_cell_if     cell_char
// o_result   out        lesf_result_if   square_size, square_col, square_row
// i_cfg      in         lesf_cfg_if      reg_index, wr_data
//
// one cell per cycle sustained, unless a grid-ending cell waits on a held result; in the processing stage
// the row-buffer entry read at a cell's transaction meets the left and up-left neighbours
// the result is registered as the last cell of the grid leaves the processing stage
// synchronous active-low reset clears counters, neighbours, best square and valids
// the row buffer is not cleared; row 0 ignores what it reads from it
// a waiting result holds only a grid-ending cell, which then blocks the input until taken

`include "assert_macros.svh"

module largest_empty_square_finder_top import lesf_pkg::*; #(
    parameter int MAX_SIDE = LESF_MAX_SIDE
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lesf_cell_if.sink     i_cell,
    lesf_result_if.source o_result,
    lesf_cfg_if.sink      i_cfg
);

    // the 11-bit grid size register bounds the side even for a larger MAX_SIDE
    localparam int SIDE_CAP = side_cap(MAX_SIDE);
    localparam int POS_W    = $clog2(SIDE_CAP);
    localparam int SZ_W     = $clog2(SIDE_CAP + 1);

    logic              cell_accept;
    logic              core_ready;
    logic              cell_free;
    logic [POS_W-1:0]  cell_col, cell_row;
    t_cell_flags       cell_flags;
    logic [SZ_W-1:0]   up_data;
    logic              wr_en;
    logic [POS_W-1:0]  wr_addr;
    logic [SZ_W-1:0]   wr_data;

    // a cell transaction completes whenever the processing stage has room
    assign i_cell.ready = core_ready;
    assign cell_accept  = i_cell.valid && core_ready;

    // configuration registers and the position of the next cell
    lesf_seq #(
        .MAX_SIDE (MAX_SIDE)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (i_cfg),
        .i_accept    (cell_accept),
        .i_cell_char (i_cell.cell_char),
        .o_free      (cell_free),
        .o_col       (cell_col),
        .o_row       (cell_row),
        .o_flags     (cell_flags)
    );

    // previous-row sizes; read at the transaction, written when the cell retires.
    // the entry for a column is written two cells or more before it is read again
    lesf_row_mem #(
        .DEPTH  (SIDE_CAP),
        .DATA_W (SZ_W)
    ) u_row_mem (
        .i_clk     (i_clk),
        .i_rd_en   (cell_accept),
        .i_rd_addr (cell_col),
        .o_rd_data (up_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // square-size recurrence, best-square tracking and result register
    lesf_core #(
        .MAX_SIDE (MAX_SIDE)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (cell_accept),
        .i_free    (cell_free),
        .i_col     (cell_col),
        .i_row     (cell_row),
        .i_flags   (cell_flags),
        .i_up      (up_data),
        .o_ready   (core_ready),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_result  (o_result)
    );

    // the cell after a grid-ending one starts a fresh grid at the origin
    `LESF_ASSERT_NEXT(a_grid_wrap, i_clk, i_rst_n, cell_accept && cell_flags.grid_end, (cell_col == '0) && (cell_row == '0), "position not back at origin after grid end")

    // a grid with no free cell reports the origin
    `LESF_ASSERT_IMPLY(a_empty_origin, i_clk, i_rst_n, o_result.valid && (o_result.square_size == '0), (o_result.square_col == '0) && (o_result.square_row == '0), "empty result with non-zero position")

    // a retiring cell writes the buffer entry of its own column only, never past the buffer
    `LESF_ASSERT_IMPLY(a_wr_in_range, i_clk, i_rst_n, wr_en, int'(wr_addr) < SIDE_CAP, "row buffer write beyond the grid")

endmodule

@@ tb/lesf_square_monitor.sv @@
`timescale 1ns / 1ps

module lesf_square_monitor import lesf_pkg::*; #(
    parameter int MAX_SIDE = LESF_MAX_SIDE
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    lesf_cell_if   cell_ch,
    lesf_result_if result_ch,
    lesf_cfg_if    cfg_ch,
    output int     o_pending,
    output int     o_fail_count
);

    typedef struct {
        logic [OUT_SIZE_W-1:0] size;
        logic [OUT_POS_W-1:0]  col;
        logic [OUT_POS_W-1:0]  row;
    } t_square;

    t_square           expected_squares[$];
    logic [CHAR_W-1:0] free_char;
    logic [GRID_W-1:0] grid_side;
    int                prev_row_sizes[MAX_SIDE];
    int                left_size;
    int                diag_size;
    int                col_pos;
    int                row_pos;
    int                best_size;
    int                best_col;
    int                best_row;
    int                fail_total = 0;
    int                pending_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;

    task automatic restart_grid();
        left_size = 0;
        diag_size = 0;
        col_pos   = 0;
        row_pos   = 0;
        best_size = 0;
        best_col  = 0;
        best_row  = 0;
    endtask

    always @(posedge i_clk) begin : track
        int      side;
        int      last;
        int      slot;
        int      up;
        int      left;
        int      diag;
        int      run;
        bit      row_end;
        bit      grid_end;
        t_square got;
        t_square want;

        if (!i_rst_n) begin
            free_char = EMPTY_CHAR_RST;
            grid_side = GRID_SIZE_RST;
            restart_grid();
            expected_squares.delete();
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.reg_index)
                    REG_EMPTY_CHAR: free_char = cfg_ch.wr_data[CHAR_W-1:0];
                    REG_GRID_SIZE:  grid_side = cfg_ch.wr_data[GRID_W-1:0];
                    default: ;
                endcase
            end

            // results first, so a result never pairs with a grid ending this cycle
            if (result_ch.valid && result_ch.ready) begin
                got.size = result_ch.square_size;
                got.col  = result_ch.square_col;
                got.row  = result_ch.square_row;
                if (expected_squares.size() == 0) begin
                    $error("unexpected result: size %0d col %0d row %0d",
                           got.size, got.col, got.row);
                    fail_total++;
                end else begin
                    want = expected_squares.pop_front();
                    if (got.size !== want.size) begin
                        $error("square_size: expected %0d, actual %0d", want.size, got.size);
                        fail_total++;
                    end
                    if (got.col !== want.col) begin
                        $error("square_col: expected %0d, actual %0d", want.col, got.col);
                        fail_total++;
                    end
                    if (got.row !== want.row) begin
                        $error("square_row: expected %0d, actual %0d", want.row, got.row);
                        fail_total++;
                    end
                end
            end

            if (cell_ch.valid && cell_ch.ready) begin
                side = (grid_side == '0) ? 1 : int'(grid_side);
                if (side > MAX_SIDE) side = MAX_SIDE;
                last = side - 1;
                slot = (col_pos < MAX_SIDE) ? col_pos : MAX_SIDE - 1;
                up   = (row_pos > 0) ? prev_row_sizes[slot] : 0;
                left = (col_pos > 0) ? left_size : 0;
                diag = (row_pos > 0 && col_pos > 0) ? diag_size : 0;
                run  = (up < left) ? up : left;
                if (diag < run) run = diag;
                run      = (cell_ch.cell_char == free_char) ? run + 1 : 0;
                row_end  = (col_pos >= last);
                grid_end = row_end && (row_pos >= last);

                if (run > best_size) begin
                    best_size = run;
                    best_col  = col_pos - (run - 1);
                    best_row  = row_pos - (run - 1);
                end
                diag_size            = up;
                prev_row_sizes[slot] = run;
                left_size            = run;

                if (grid_end) begin
                    want.size = OUT_SIZE_W'(best_size);
                    want.col  = OUT_POS_W'(best_col);
                    want.row  = OUT_POS_W'(best_row);
                    expected_squares.push_back(want);
                    restart_grid();
                end else if (row_end) begin
                    col_pos = 0;
                    row_pos = row_pos + 1;
                end else begin
                    col_pos = col_pos + 1;
                end
            end
        end
        pending_total = expected_squares.size();
    end

endmodule

@@ tb/largest_empty_square_finder_top_tb.sv @@
`timescale 1ns / 1ps

module largest_empty_square_finder_top_tb;
    import lesf_pkg::*;

    localparam int CLK_HALF_NS      = 5;
    localparam int RESET_CYCLES     = 11;
    // run limit, set far above the length of the slowest correct run
    localparam int CYCLE_LIMIT      = 500000;
    // the result is registered as the grid-ending cell retires after its transaction; some margin
    localparam int SETTLE_CYCLES    = 8;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int RANDOM_CELLS     = 480;
    localparam int MIN_RANDOM_GRIDS = 8;

    // register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef enum int {
        STALL_NONE,
        STALL_HALF,
        STALL_HEAVY
    } t_stall_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lesf_cell_if   cell_if();
    lesf_result_if result_if();
    lesf_cfg_if    cfg_if();

    int square_pending;
    int square_fails;

    largest_empty_square_finder_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cell   (cell_if),
        .o_result (result_if),
        .i_cfg    (cfg_if)
    );

    // prediction and comparison live beside the block
    lesf_square_monitor square_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .cell_ch      (cell_if),
        .result_ch    (result_if),
        .cfg_ch       (cfg_if),
        .o_pending    (square_pending),
        .o_fail_count (square_fails)
    );

    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    // run limit, counted on every rising edge
    int cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("largest_empty_square_finder_top test failed");
            $finish;
        end
    end

    // stimulus state
    logic [CHAR_W-1:0] cur_free;
    int                burst_left = 0;
    int                side_now;
    int                cells_sent;
    int                grids_done;
    int                part_cells;
    int                hold_requests = 0;
    int                holds_done = 0;

    // one cell transaction; the sender may idle between bursts of random length
    task automatic send_cell(input logic [CHAR_W-1:0] ch);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            // now and then a long burst with no idling at all
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 40);
            if (gap > 0) begin
                cell_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        cell_if.valid     <= 1'b1;
        cell_if.cell_char <= ch;
        @(posedge i_clk);
        while (!cell_if.ready) @(posedge i_clk);
        burst_left--;
    endtask

    // cells that are free with the given percentage, otherwise any character
    task automatic send_cells(input int count, input int free_pct);
        int                n;
        logic [CHAR_W-1:0] ch;
        for (n = 0; n < count; n++) begin
            ch = ($urandom_range(1, 100) <= free_pct) ? cur_free
                                                      : CHAR_W'($urandom_range(0, 255));
            send_cell(ch);
        end
    endtask

    // stop sending, wait for every predicted square, then let the pipeline empty
    task automatic drain_results();
        cell_if.valid <= 1'b0;
        burst_left = 0;
        repeat (2) @(posedge i_clk);
        while (square_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_if.valid     <= 1'b1;
        cfg_if.reg_index <= idx;
        cfg_if.wr_data   <= data;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_EMPTY_CHAR) cur_free = data[CHAR_W-1:0];
    endtask

    // receiver: random stall modes, plus a long hold-off on request
    initial begin : receiver
        t_stall_mode stall_mode;
        int          mode_left;
        stall_mode = STALL_NONE;
        mode_left  = 0;
        result_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_requests != holds_done) begin
                result_if.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                holds_done++;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = t_stall_mode'($urandom_range(0, 2));
                    mode_left  = $urandom_range(16, 120);
                end
                mode_left--;
                case (stall_mode)
                    STALL_NONE: result_if.ready <= 1'b1;
                    STALL_HALF: result_if.ready <= 1'($urandom_range(0, 1));
                    default:    result_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin
        i_rst_n           <= 1'b0;
        cell_if.valid     <= 1'b0;
        cell_if.cell_char <= '0;
        cfg_if.valid      <= 1'b0;
        cfg_if.reg_index  <= REG_EMPTY_CHAR;
        cfg_if.wr_data    <= '0;
        cur_free = EMPTY_CHAR_RST;
        side_now = 1;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // ---- directed part ----

        // single-cell grids with the reset empty character: one free, one blocked
        write_reg(REG_GRID_SIZE, CFG_DATA_W'(1));
        send_cell(EMPTY_CHAR_RST);
        send_cell(EMPTY_CHAR_RST + 8'd1);

        // upper data bits dropped for the empty character; grid size zero acts as one
        drain_results();
        write_reg(REG_EMPTY_CHAR, '1);
        write_reg(REG_GRID_SIZE, '0);
        send_cell(8'hFF);
        send_cell(8'h00);
        send_cell(8'hFE);

        // whole 2x2 grid free
        drain_results();
        write_reg(REG_EMPTY_CHAR, '0);
        write_reg(REG_GRID_SIZE, CFG_DATA_W'(2));
        repeat (4) send_cell(8'h00);

        // writes to unused indexes must leave both registers alone
        drain_results();
        write_reg(REG_SPARE_A, CFG_DATA_W'($urandom_range(0, 2047)));
        write_reg(REG_SPARE_B, '1);
        repeat (4) send_cell(8'h00);

        // 3x3 grid with no free cell but the last: square in the far corner
        drain_results();
        write_reg(REG_GRID_SIZE, CFG_DATA_W'(3));
        repeat (8) send_cell(8'h80);
        send_cell(8'h00);

        // grid size lowered mid-grid: the current position ends the grid
        drain_results();
        write_reg(REG_GRID_SIZE, CFG_DATA_W'(4));
        repeat (6) send_cell(8'h00);
        drain_results();
        write_reg(REG_GRID_SIZE, CFG_DATA_W'(2));
        send_cell(8'h00);

        // ---- long receiver hold-off: single-cell grids back up into the input ----
        drain_results();
        write_reg(REG_EMPTY_CHAR, CFG_DATA_W'($urandom_range(0, 255)));
        write_reg(REG_GRID_SIZE, CFG_DATA_W'(1));
        hold_requests++;
        send_cells(12, 50);

        // ---- oversized grid size: a few cells, then size one so the next cell ends it ----
        drain_results();
        write_reg(REG_EMPTY_CHAR, CFG_DATA_W'(EMPTY_CHAR_RST));
        write_reg(REG_GRID_SIZE, CFG_DATA_W'(GRID_SIZE_MAX));
        send_cells(5, 90);
        drain_results();
        write_reg(REG_GRID_SIZE, CFG_DATA_W'(1));
        send_cell(cur_free);
        side_now = 1;

        // ---- random part: mostly small grids, some back to back ----
        cells_sent = 0;
        grids_done = 0;
        while (cells_sent < RANDOM_CELLS || grids_done < MIN_RANDOM_GRIDS) begin
            if (grids_done == 0 || $urandom_range(0, 99) < 60) begin
                drain_results();
                side_now = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                       : $urandom_range(1, 8);
                write_reg(REG_GRID_SIZE, CFG_DATA_W'(side_now));
                if ($urandom_range(0, 3) == 0)
                    write_reg(REG_EMPTY_CHAR, CFG_DATA_W'($urandom_range(0, 2047)));
                if ($urandom_range(0, 7) == 0)
                    write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                              CFG_DATA_W'($urandom_range(0, 2047)));
            end
            if (side_now > 1 && $urandom_range(0, 7) == 0) begin
                // part of a grid, then shrink to one so the next cell closes it
                part_cells = $urandom_range(1, side_now * side_now - 1);
                send_cells(part_cells, $urandom_range(40, 100));
                drain_results();
                write_reg(REG_GRID_SIZE, CFG_DATA_W'(1));
                send_cells(1, 50);
                cells_sent += part_cells + 1;
                side_now = 1;
            end else begin
                send_cells(side_now * side_now, $urandom_range(40, 100));
                cells_sent += side_now * side_now;
            end
            grids_done++;
        end

        drain_results();
        if (square_fails == 0) begin
            $display("largest_empty_square_finder_top test passed");
        end else begin
            $display("largest_empty_square_finder_top test failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/lesf_pkg.sv
design/lesf_if.sv
design/lesf_row_mem.sv
design/lesf_seq.sv
design/lesf_core.sv
design/largest_empty_square_finder_top.sv
tb/lesf_square_monitor.sv
tb/largest_empty_square_finder_top_tb.sv
